// ----- hdl/polyline_delta_stream_decoder_macros.svh -----
// Assertion macros for the polyline delta stream decoder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef POLYLINE_DELTA_STREAM_DECODER_MACROS_SVH
`define POLYLINE_DELTA_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define PDSD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdsd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PDSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdsd: next-cycle check failed");

`else

`define PDSD_ASSERT_IMPLIES(label, ante, cons)
`define PDSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/pdsd_pkg.sv -----
`default_nettype none

package pdsd_pkg;

	// Parse phases.
	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_LCOUNT = 4'd1;
	localparam logic [3:0] PH_TOTAL  = 4'd2;
	localparam logic [3:0] PH_PROT   = 4'd3;
	localparam logic [3:0] PH_NPTS   = 4'd4;
	localparam logic [3:0] PH_SX     = 4'd5;
	localparam logic [3:0] PH_SY     = 4'd6;
	localparam logic [3:0] PH_D1     = 4'd7;
	localparam logic [3:0] PH_D2     = 4'd8;
	localparam logic [3:0] PH_D3     = 4'd9;
	localparam logic [3:0] PH_D4     = 4'd10;
	localparam logic [3:0] PH_DONE   = 4'd11;

	// Result kinds.
	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_MAGIC = 2'd2;
	localparam logic [1:0] KIND_TRUNC = 2'd3;

	// Header signature, first byte in the lowest slot.
	localparam logic [3:0][7:0] MAGIC = {8'h42, 8'h44, 8'h52, 8'h4E};

	// Versions from which the total length and the long delta form appear.
	localparam logic [11:0] VER_TOTAL      = 12'd22;
	localparam logic [11:0] VER_LONG_DELTA = 12'd23;

	// Magnitude width: the longest delta form reaches bit 28.
	localparam int MAG_W = 29;

	typedef logic [MAG_W-1:0] mag_t;

endpackage

`default_nettype wire

// ----- hdl/polyline_delta_stream_decoder.sv -----
// Path: an accepted byte waits in the input register; a single pass of logic
// parses it into the result register, unless a stalled result holds it back.
// Throughput: one byte per cycle while the result is not stalled; the parse
// state is updated once per byte, between the input and result registers.
// Reset: arst_n clears all parse state and both valid flags at once; the block
// takes bytes from the first edge after reset is released.
`default_nettype none

`include "polyline_delta_stream_decoder_macros.svh"

module polyline_delta_stream_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               line_end,
	output logic               stream_end
);
	import pdsd_pkg::*;

	// Input register: holds one accepted beat until the parser can take it.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Result register, which drives the output port.
	logic               valid_s2;
	logic [1:0]         kind_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] y_s2;
	logic               line_end_s2;
	logic               stream_end_s2;

	// Parse state.
	logic [3:0]  phase_q;
	logic [2:0]  pos_q;
	logic [11:0] version_q;
	logic        prot_q;
	logic [31:0] lines_q;
	logic [31:0] points_q;
	logic [23:0] word_q;
	mag_t        mag_q;
	logic        neg_q;
	logic        is_y_q;
	logic [31:0] x_q;
	logic [31:0] y_q;

	// Next-state values.
	logic [3:0]  phase_n;
	logic [2:0]  pos_n;
	logic [11:0] version_n;
	logic        prot_n;
	logic [31:0] lines_n;
	logic [31:0] points_n;
	logic [23:0] word_n;
	mag_t        mag_n;
	logic        neg_n;
	logic        is_y_n;
	logic [31:0] x_n;
	logic [31:0] y_n;

	// Result of the byte being parsed.
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [31:0] res_x;
	logic [31:0] res_y;
	logic        res_le;
	logic        res_se;

	// Internal events raised inside the phase decode.
	logic        advance;
	logic        word_last;
	logic [31:0] word_full;
	logic        body_enter;
	logic        lines_start;
	logic [31:0] lines_sel;
	logic        delta_done;
	logic [31:0] delta_target;
	logic [31:0] delta_sum;
	logic        emit_point;
	logic        points_zero;
	logic [31:0] emit_x;
	logic [31:0] emit_y;

	// Shorthands used by the checks at the end.
	logic        in_delta;
	logic        out_point;

	// The parser takes the held beat whenever the result register is empty or
	// is being emptied in this cycle. The input side is only held off while a
	// beat waits in the input register and the result register is stuck.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && valid_s2 && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	// A multi-byte little-endian word completes on its fourth beat; the first
	// three are kept in word_q and the fourth is used straight from the input.
	assign word_last = (pos_q[1:0] == 2'd3);
	assign word_full = {byte_s1, word_q};

	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		version_n    = version_q;
		prot_n       = prot_q;
		lines_n      = lines_q;
		points_n     = points_q;
		word_n       = word_q;
		mag_n        = mag_q;
		neg_n        = neg_q;
		is_y_n       = is_y_q;
		x_n          = x_q;
		y_n          = y_q;
		res_valid    = 1'b0;
		res_kind     = KIND_POINT;
		res_x        = 32'd0;
		res_y        = 32'd0;
		res_le       = 1'b0;
		res_se       = 1'b0;
		body_enter   = 1'b0;
		lines_start  = 1'b0;
		lines_sel    = lines_q;
		delta_done   = 1'b0;
		emit_point   = 1'b0;
		points_zero  = 1'b0;
		emit_x       = x_q;
		emit_y       = y_q;

		// Gathering phases share the byte deposit; the completed word is
		// consumed in the phase arms below.
		if ((phase_q inside {PH_LCOUNT, PH_TOTAL, PH_NPTS, PH_SX, PH_SY}) && !word_last) begin
			case (pos_q[1:0])
				2'd0:    word_n[7:0]   = byte_s1;
				2'd1:    word_n[15:8]  = byte_s1;
				default: word_n[23:16] = byte_s1;
			endcase
			pos_n = pos_q + 3'd1;
		end

		case (phase_q)
			PH_HEADER: begin
				if (!pos_q[2] && byte_s1 != MAGIC[pos_q[1:0]]) begin
					// Bad signature: report it and ignore the rest of the blob.
					phase_n   = PH_DONE;
					res_valid = 1'b1;
					res_kind  = KIND_MAGIC;
				end else begin
					if (pos_q == 3'd4) begin
						version_n = 12'({4'b0000, byte_s1} * 12'd10);
					end
					if (pos_q == 3'd5) begin
						version_n = version_q + {4'b0000, byte_s1};
					end
					if (pos_q == 3'd7) begin
						prot_n  = |byte_s1;
						phase_n = PH_LCOUNT;
						pos_n   = 3'd0;
						word_n  = 24'd0;
					end else begin
						pos_n = pos_q + 3'd1;
					end
				end
			end
			PH_LCOUNT: begin
				if (word_last) begin
					pos_n     = 3'd0;
					word_n    = 24'd0;
					lines_n   = word_full[31] ? 32'd0 : word_full;
					lines_sel = lines_n;
					if (version_q >= VER_TOTAL) begin
						phase_n = PH_TOTAL;
					end else begin
						body_enter = 1'b1;
					end
				end
			end
			PH_TOTAL: begin
				if (word_last) begin
					pos_n      = 3'd0;
					word_n     = 24'd0;
					body_enter = 1'b1;
				end
			end
			PH_PROT: begin
				if (byte_s1 == 8'd0) begin
					lines_start = 1'b1;
				end
			end
			PH_NPTS: begin
				if (word_last) begin
					pos_n    = 3'd0;
					word_n   = 24'd0;
					points_n = (word_full[31] || word_full < 32'd2) ? 32'd0
					                                               : word_full - 32'd1;
					phase_n  = PH_SX;
				end
			end
			PH_SX: begin
				if (word_last) begin
					pos_n   = 3'd0;
					word_n  = 24'd0;
					x_n     = word_full;
					phase_n = PH_SY;
				end
			end
			PH_SY: begin
				if (word_last) begin
					pos_n       = 3'd0;
					word_n      = 24'd0;
					y_n         = word_full;
					is_y_n      = 1'b0;
					emit_point  = 1'b1;
					points_zero = (points_q == 32'd0);
					emit_y      = word_full;
				end
			end
			PH_D1: begin
				neg_n   = byte_s1[6];
				mag_n   = mag_t'(byte_s1[5:0]);
				pos_n   = {2'b00, byte_s1[7]};
				phase_n = PH_D2;
			end
			PH_D2: begin
				mag_n = mag_t'({byte_s1, mag_q[5:0]});
				pos_n = 3'd0;
				if (pos_q[0]) begin
					phase_n = PH_D3;
				end else begin
					delta_done = 1'b1;
				end
			end
			PH_D3: begin
				if (version_q >= VER_LONG_DELTA) begin
					mag_n = mag_t'({byte_s1[6:0], mag_q[13:0]});
					if (byte_s1[7]) begin
						phase_n = PH_D4;
					end else begin
						delta_done = 1'b1;
					end
				end else begin
					mag_n      = mag_t'({byte_s1, mag_q[13:0]});
					delta_done = 1'b1;
				end
			end
			PH_D4: begin
				mag_n      = {byte_s1, mag_q[20:0]};
				delta_done = 1'b1;
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// Deltas are applied as one add or subtract on the coordinate they target.
		delta_target = is_y_q ? y_q : x_q;
		delta_sum    = neg_q ? (delta_target - {3'b000, mag_n})
		                     : (delta_target + {3'b000, mag_n});

		// A complete delta moves x first, then y; the y half completes a point.
		if (delta_done) begin
			if (!is_y_q) begin
				x_n     = delta_sum;
				is_y_n  = 1'b1;
				phase_n = PH_D1;
			end else begin
				y_n         = delta_sum;
				is_y_n      = 1'b0;
				points_n    = points_q - 32'd1;
				emit_point  = 1'b1;
				points_zero = (points_q == 32'd1);
				emit_y      = delta_sum;
			end
		end

		if (body_enter) begin
			if (prot_q) begin
				phase_n = PH_PROT;
			end else begin
				lines_start = 1'b1;
			end
		end

		if (lines_start) begin
			pos_n  = 3'd0;
			word_n = 24'd0;
			if (lines_sel == 32'd0) begin
				phase_n   = PH_DONE;
				res_valid = 1'b1;
				res_kind  = KIND_EMPTY;
				res_se    = 1'b1;
			end else begin
				phase_n = PH_NPTS;
			end
		end

		if (emit_point) begin
			res_valid = 1'b1;
			res_kind  = KIND_POINT;
			res_x     = emit_x;
			res_y     = emit_y;
			if (points_zero) begin
				// Last point of the line.
				lines_n = lines_q - 32'd1;
				res_le  = 1'b1;
				pos_n   = 3'd0;
				word_n  = 24'd0;
				if (lines_q == 32'd1) begin
					res_se  = 1'b1;
					phase_n = PH_DONE;
				end else begin
					phase_n = PH_NPTS;
				end
			end else begin
				phase_n = PH_D1;
			end
		end

		// The final beat of a blob ends the parse; an unfinished stream is
		// reported as truncated, in place of any point this beat completed.
		if (final_s1) begin
			if (phase_n != PH_DONE) begin
				res_valid = 1'b1;
				res_kind  = KIND_TRUNC;
				res_x     = 32'd0;
				res_y     = 32'd0;
				res_le    = 1'b0;
				res_se    = 1'b0;
			end
			phase_n   = PH_HEADER;
			pos_n     = 3'd0;
			version_n = 12'd0;
			prot_n    = 1'b0;
			lines_n   = 32'd0;
			points_n  = 32'd0;
			word_n    = 24'd0;
			mag_n     = '0;
			neg_n     = 1'b0;
			is_y_n    = 1'b0;
			x_n       = 32'd0;
			y_n       = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= 3'd0;
			version_q <= 12'd0;
			prot_q    <= 1'b0;
			lines_q   <= 32'd0;
			points_q  <= 32'd0;
			word_q    <= 24'd0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			is_y_q    <= 1'b0;
			x_q       <= 32'd0;
			y_q       <= 32'd0;
		end else if (advance) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			version_q <= version_n;
			prot_q    <= prot_n;
			lines_q   <= lines_n;
			points_q  <= points_n;
			word_q    <= word_n;
			mag_q     <= mag_n;
			neg_q     <= neg_n;
			is_y_q    <= is_y_n;
			x_q       <= x_n;
			y_q       <= y_n;
		end
	end

	// The result register is loaded whenever the parser advances, and empties
	// once its beat is taken with nothing new behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_s2       <= res_kind;
			x_s2          <= $signed(res_x);
			y_s2          <= $signed(res_y);
			line_end_s2   <= res_le;
			stream_end_s2 <= res_se;
		end
	end

	assign result_valid = valid_s2;
	assign kind         = kind_s2;
	assign point_x      = x_s2;
	assign point_y      = y_s2;
	assign line_end     = line_end_s2;
	assign stream_end   = stream_end_s2;

	assign in_delta  = phase_q inside {PH_D1, PH_D2, PH_D3, PH_D4};
	assign out_point = valid_s2 && (kind_s2 == KIND_POINT);

	// Only point results carry coordinates or a line end.
	`PDSD_ASSERT_IMPLIES(a_nonpoint_clear, valid_s2 && !out_point, ~|{x_s2, y_s2, line_end_s2})

	// The end of the stream on a point is always the end of a line too.
	`PDSD_ASSERT_IMPLIES(a_stream_end_on_line_end, out_point && stream_end_s2, line_end_s2)

	// Deltas are only read while the current line still owes points.
	`PDSD_ASSERT_IMPLIES(a_delta_has_points, in_delta, points_q != 32'd0)

	// A final beat always leaves the parser back in its header phase.
	`PDSD_ASSERT_NEXT(a_final_rearms, advance && final_s1, phase_q == PH_HEADER && pos_q == 3'd0)

endmodule

`default_nettype wire
